@@ hdl/dpc_pkg.sv @@
package dpc_pkg;

	localparam int DEPTH_W  = 16;
	localparam int COLOR_W  = 32;
	localparam int POINT_W  = 32;
	localparam int Z_W      = 23;
	localparam int SIZE_W   = 13;
	localparam int PARAM_W  = 16;
	localparam int POS_W    = 12;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// depth * 65536 / 1000 == (depth << 13) / 125
	localparam int NUM_W    = DEPTH_W + 13;
	localparam int RECIP_W  = 30;
	localparam int RECIP_SH = 36;
	localparam logic [RECIP_W-1:0] Z_RECIP = 30'd549755813;   // floor(2^36 / 125)
	localparam logic [RECIP_W-1:0] Z_DIVISOR = 30'd125;
	localparam logic [Z_W-1:0] Z_MAX = 23'd4294901;

	// offset magnitude (16 bit) times z (23 bit)
	localparam int PROD_W   = PARAM_W + Z_W;
	localparam int QUO_W    = 32;

	localparam logic [SIZE_W-1:0]  RST_FRAME_WIDTH  = 13'd640;
	localparam logic [SIZE_W-1:0]  RST_FRAME_HEIGHT = 13'd480;
	localparam logic [PARAM_W-1:0] RST_CENTER_X     = 16'd5120;
	localparam logic [PARAM_W-1:0] RST_CENTER_Y     = 16'd3840;
	localparam logic [PARAM_W-1:0] RST_FOCAL_X      = 16'd11200;
	localparam logic [PARAM_W-1:0] RST_FOCAL_Y      = 16'd11200;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 3'd0,
		CFG_FRAME_HEIGHT = 3'd1,
		CFG_CENTER_X     = 3'd2,
		CFG_CENTER_Y     = 3'd3,
		CFG_FOCAL_X      = 3'd4,
		CFG_FOCAL_Y      = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic                start;
		logic [PROD_W-1:0]   dividend;
		logic [PARAM_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [QUO_W-1:0]    quotient;
	} div_rsp_t;

endpackage

@@ hdl/dpc_if.sv @@
interface dpc_cfg_if import dpc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

interface dpc_pixel_if import dpc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DEPTH_W-1:0] depth_mm;
	logic [COLOR_W-1:0] pixel_color;
	logic               frame_start;

	modport source (output valid, depth_mm, pixel_color, frame_start, input ready);
	modport sink (input valid, depth_mm, pixel_color, frame_start, output ready);
endinterface

interface dpc_point_if import dpc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [POINT_W-1:0] point_x;
	logic [POINT_W-1:0] point_y;
	logic [Z_W-1:0]     point_z;
	logic [COLOR_W-1:0] point_color;
	logic               frame_end;

	modport source (output valid, point_x, point_y, point_z, point_color, frame_end,
		input ready);
	modport sink (input valid, point_x, point_y, point_z, point_color, frame_end,
		output ready);
endinterface

@@ hdl/dpc_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
// The upper dividend bits must already be below the divisor.
module dpc_div import dpc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic                busy_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [PARAM_W-1:0]  rem_q;
	logic [PARAM_W-1:0]  div_q;
	logic [QUO_W-1:0]    quo_q;
	logic [PARAM_W:0]    trial;
	logic                take;

	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign take  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(QUO_W);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= PARAM_W'(req.dividend[PROD_W-1:QUO_W]);
			quo_q <= req.dividend[QUO_W-1:0];
			div_q <= req.divisor;
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= take ? PARAM_W'(trial - {1'b0, div_q}) : trial[PARAM_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], take};
		end
	end

	assign rsp.done     = busy_q && cnt_q == '0;
	assign rsp.quotient = quo_q;

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < div_q)
		else $error("divider remainder not below divisor");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done && !req.start |=> !busy_q)
		else $error("divider stayed busy after done");

endmodule

@@ hdl/depth_to_point_cloud_unit.sv @@
// Channel    Role    Beat contents
// cfg        sink    index (register number), data (register value)
// pixel_in   sink    depth_mm, pixel_color, frame_start
// point_out  source  point_x, point_y, point_z, point_color, frame_end
//
// Each axis whose quotient cannot fit 32 bits skips its division and saturates. The
// single shared radix-2 divider produces one quotient bit per cycle, at most two quotients
// per pixel. pixel_in is ready only in IDLE; the finished point sits in an output
// register, so a stalled point_out holds the next point in DONE only. cfg is always ready
// and registers reset to their documented defaults; counters reset to column 0, row 0.
module depth_to_point_cloud_unit import dpc_pkg::*; #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	dpc_cfg_if.sink     cfg,
	dpc_pixel_if.sink   pixel_in,
	dpc_point_if.source point_out
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_ZMUL   = 7'b0000010,
		S_ZFIX   = 7'b0000100,
		S_PMUL   = 7'b0001000,
		S_LAUNCH = 7'b0010000,
		S_WAIT   = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	// configuration registers
	logic [SIZE_W-1:0]  frame_width_q, frame_height_q;
	logic [PARAM_W-1:0] center_x_q, center_y_q, focal_x_q, focal_y_q;

	// raster position
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	state_t             state_q;
	logic               axis_q;      // 0: x, 1: y
	logic [NUM_W-1:0]   num_q;
	logic [Z_W-1:0]     zest_q, z_q;
	logic [POS_W-1:0]   col_pos_q, row_pos_q;
	logic [COLOR_W-1:0] color_q;
	logic               fend_q;
	logic [PROD_W-1:0]  prod_q;
	logic               neg_q;
	logic [PARAM_W-1:0] fdiv_q;
	logic [POINT_W-1:0] x_q, y_q;

	logic               out_valid_q;
	logic [POINT_W-1:0] out_x_q, out_y_q;
	logic [Z_W-1:0]     out_z_q;
	logic [COLOR_W-1:0] out_color_q;
	logic               out_fend_q;

	logic               in_beat, out_beat;
	logic [SIZE_W-1:0]  wm1, hm1;
	logic [COL_W-1:0]   col_eff;
	logic [ROW_W-1:0]   row_eff;
	logic               row_end, frame_end;

	logic [NUM_W+RECIP_W-1:0] zprod;
	logic [RECIP_W-1:0]       zrem;

	logic [POS_W-1:0]   pos_sel;
	logic [PARAM_W-1:0] center_sel, focal_sel;
	logic signed [PARAM_W+1:0] offset;
	logic [PARAM_W+1:0] offset_mag;
	logic               ovf;
	logic [POINT_W-1:0] result;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// Clamp a quotient magnitude into signed 32 bits and apply the sign.
	function automatic logic [POINT_W-1:0] saturate(logic neg, logic over,
		logic [QUO_W-1:0] q);
		logic [POINT_W-1:0] r;
		if (!neg) begin
			r = (over || q[QUO_W-1]) ? {1'b0, {(POINT_W-1){1'b1}}} : q;
		end else if (over || (q[QUO_W-1] && q[QUO_W-2:0] != '0)) begin
			r = {1'b1, {(POINT_W-1){1'b0}}};
		end else begin
			r = -q;
		end
		return r;
	endfunction

	assign in_beat  = pixel_in.valid && pixel_in.ready;
	assign out_beat = point_out.valid && point_out.ready;

	assign cfg.ready      = 1'b1;
	assign pixel_in.ready = state_q == S_IDLE;

	// Effective last column / last row: zero acts as one, oversize clamps to the maximum.
	always_comb begin
		if (frame_width_q == '0) begin
			wm1 = '0;
		end else if (frame_width_q > SIZE_W'(MAX_WIDTH)) begin
			wm1 = SIZE_W'(MAX_WIDTH - 1);
		end else begin
			wm1 = frame_width_q - 1'b1;
		end
		if (frame_height_q == '0) begin
			hm1 = '0;
		end else if (frame_height_q > SIZE_W'(MAX_HEIGHT)) begin
			hm1 = SIZE_W'(MAX_HEIGHT - 1);
		end else begin
			hm1 = frame_height_q - 1'b1;
		end
	end

	// frame_start takes the pixel at the origin before the wrap checks
	assign col_eff   = pixel_in.frame_start ? '0 : col_q;
	assign row_eff   = pixel_in.frame_start ? '0 : row_q;
	assign row_end   = SIZE_W'(col_eff) >= wm1;
	assign frame_end = row_end && SIZE_W'(row_eff) >= hm1;

	// z estimate by reciprocal, low by at most one; ZFIX corrects it
	assign zprod = NUM_W'(num_q) * RECIP_W'(Z_RECIP);
	assign zrem  = RECIP_W'(num_q) - RECIP_W'(zest_q) * Z_DIVISOR;

	// offset in Q.4 pixels for the axis in progress
	always_comb begin
		pos_sel    = axis_q ? row_pos_q : col_pos_q;
		center_sel = axis_q ? center_y_q : center_x_q;
		focal_sel  = axis_q ? focal_y_q : focal_x_q;
		offset     = $signed({2'b00, pos_sel, 4'b0000}) - $signed({2'b00, center_sel});
		offset_mag = offset[PARAM_W+1] ? -offset : offset;
	end

	// quotient cannot fit 32 bits when the bits above it already reach the divisor
	assign ovf = PARAM_W'(prod_q[PROD_W-1:QUO_W]) >= fdiv_q;

	assign result = saturate(neg_q, state_q == S_LAUNCH && ovf, div_rsp.quotient);

	assign div_req.start    = state_q == S_LAUNCH && !ovf;
	assign div_req.dividend = prod_q;
	assign div_req.divisor  = fdiv_q;

	dpc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
			center_x_q     <= RST_CENTER_X;
			center_y_q     <= RST_CENTER_Y;
			focal_x_q      <= RST_FOCAL_X;
			focal_y_q      <= RST_FOCAL_Y;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg.data[SIZE_W-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg.data[SIZE_W-1:0];
				CFG_CENTER_X:     center_x_q     <= cfg.data;
				CFG_CENTER_Y:     center_y_q     <= cfg.data;
				CFG_FOCAL_X:      focal_x_q      <= cfg.data;
				CFG_FOCAL_Y:      focal_y_q      <= cfg.data;
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	// sequencer and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop valid once the point leaves, unless DONE reloads it on the same edge
			if (out_beat && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						// advance the raster position right at acceptance
						if (row_end) begin
							col_q <= '0;
							row_q <= frame_end ? '0 : row_eff + 1'b1;
						end else begin
							col_q <= col_eff + 1'b1;
							row_q <= row_eff;
						end
						state_q <= S_ZMUL;
					end
				end
				S_ZMUL: state_q <= S_ZFIX;
				S_ZFIX: begin
					axis_q  <= 1'b0;
					state_q <= S_PMUL;
				end
				S_PMUL: state_q <= S_LAUNCH;
				S_LAUNCH: begin
					if (ovf) begin
						// saturated without dividing
						axis_q  <= 1'b1;
						state_q <= axis_q ? S_DONE : S_PMUL;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (div_rsp.done) begin
						axis_q  <= 1'b1;
						state_q <= axis_q ? S_DONE : S_PMUL;
					end
				end
				S_DONE: begin
					// hold while the output register still owns an unsent point
					if (!out_valid_q || point_out.ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_beat) begin
			num_q     <= {pixel_in.depth_mm, 13'd0};
			color_q   <= pixel_in.pixel_color;
			fend_q    <= frame_end;
			col_pos_q <= POS_W'(col_eff);
			row_pos_q <= POS_W'(row_eff);
		end
		if (state_q == S_ZMUL) begin
			zest_q <= zprod[RECIP_SH +: Z_W];
		end
		if (state_q == S_ZFIX) begin
			z_q <= zest_q + Z_W'(zrem >= Z_DIVISOR);
		end
		if (state_q == S_PMUL) begin
			prod_q <= offset_mag[PARAM_W-1:0] * z_q;
			neg_q  <= offset[PARAM_W+1];
			fdiv_q <= (focal_sel == '0) ? PARAM_W'(1) : focal_sel;
		end
		if ((state_q == S_LAUNCH && ovf) || (state_q == S_WAIT && div_rsp.done)) begin
			if (axis_q) begin
				y_q <= result;
			end else begin
				x_q <= result;
			end
		end
		if (state_q == S_DONE && (!out_valid_q || point_out.ready)) begin
			out_x_q     <= x_q;
			out_y_q     <= y_q;
			out_z_q     <= z_q;
			out_color_q <= color_q;
			out_fend_q  <= fend_q;
		end
	end

	assign point_out.valid       = out_valid_q;
	assign point_out.point_x     = out_x_q;
	assign point_out.point_y     = out_y_q;
	assign point_out.point_z     = out_z_q;
	assign point_out.point_color = out_color_q;
	assign point_out.frame_end   = out_fend_q;

	a_one_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !pixel_in.ready)
		else $error("second pixel accepted while one is in flight");

	a_z_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PMUL |-> z_q <= Z_MAX)
		else $error("depth conversion out of range");

	a_zero_depth: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && z_q == '0 |-> x_q == '0 && y_q == '0)
		else $error("zero depth gave a nonzero point");

	a_no_div_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_WAIT)
		else $error("divider result outside the wait state");

endmodule

@@ tb/depth_to_point_cloud_unit_tb.sv @@
module depth_to_point_cloud_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dpc_pkg::*;

	localparam int unsigned FRAME_MAX_W  = 4096;
	localparam int unsigned FRAME_MAX_H  = 4096;
	localparam int unsigned MM_PER_M     = 1000;
	localparam int unsigned Z_FRAC       = 16;
	localparam int unsigned RANDOM_ITEMS = 1050;

	// register slots past the last defined one; the block must ignore them
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth_mm;
		logic [COLOR_W-1:0] pixel_color;
		logic               frame_start;
	} pixel_t;

	typedef struct packed {
		logic [POINT_W-1:0] x;
		logic [POINT_W-1:0] y;
		logic [Z_W-1:0]     z;
		logic [COLOR_W-1:0] color;
		logic               frame_end;
	} point_t;

	logic clk = 1'b0;
	logic arst_n;

	dpc_cfg_if   cfg();
	dpc_pixel_if pixel_in();
	dpc_point_if point_out();

	depth_to_point_cloud_unit #(
		.MAX_WIDTH (FRAME_MAX_W),
		.MAX_HEIGHT(FRAME_MAX_H)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.pixel_in (pixel_in),
		.point_out(point_out)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow of the block's registers and raster counters.
	logic [SIZE_W-1:0]  frame_width_r  = RST_FRAME_WIDTH;
	logic [SIZE_W-1:0]  frame_height_r = RST_FRAME_HEIGHT;
	logic [PARAM_W-1:0] center_x_r     = RST_CENTER_X;
	logic [PARAM_W-1:0] center_y_r     = RST_CENTER_Y;
	logic [PARAM_W-1:0] focal_x_r      = RST_FOCAL_X;
	logic [PARAM_W-1:0] focal_y_r      = RST_FOCAL_Y;
	logic [POS_W-1:0]   column_pos     = '0;
	logic [POS_W-1:0]   row_pos        = '0;

	pixel_t      queued_pixels[$];
	point_t      pending_points[$];
	pixel_t      shown_pixel;
	point_t      want;
	bit          pix_busy    = 1'b0;
	bit          pixel_taken = 1'b0;
	bit          point_taken = 1'b0;
	bit          sender_calm = 1'b0;
	bit          sink_calm   = 1'b0;
	int unsigned pix_gap     = 0;
	int unsigned sink_hold   = 0;
	int unsigned error_count = 0;

	// Size registers: zero acts as one, anything past the maximum acts as the maximum.
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
			input int unsigned lim);
		if (v == '0)
			return SIZE_W'(1);
		if (v > lim)
			return SIZE_W'(lim);
		return v;
	endfunction

	// (pos*16 - center) * z / focal, truncated toward zero, saturated to 32 bits.
	function automatic logic [POINT_W-1:0] offset_to_meters(input logic [POS_W-1:0] pos,
			input logic [PARAM_W-1:0] center, input logic [PARAM_W-1:0] focal,
			input logic [Z_W-1:0] z);
		logic signed [18:0] offs;
		logic [16:0]        mag;
		logic [63:0]        quo;
		logic [PARAM_W-1:0] div;
		offs = $signed({3'b000, pos, 4'b0000}) - $signed({3'b000, center});
		mag  = 17'(offs < 0 ? -offs : offs);
		div  = (focal == '0) ? PARAM_W'(1) : focal;
		quo  = (64'(mag) * 64'(z)) / 64'(div);
		if (offs >= 0)
			return (quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
		if (quo > 64'h8000_0000)
			quo = 64'h8000_0000;
		return -quo[31:0];
	endfunction

	// Work out the point for one pixel beat and advance the raster counters.
	function automatic point_t project_pixel(input pixel_t px);
		point_t            pt;
		logic [SIZE_W-1:0] w;
		logic [SIZE_W-1:0] h;
		logic [Z_W-1:0]    z;
		logic              row_end;
		w = clamp_size(frame_width_r, FRAME_MAX_W);
		h = clamp_size(frame_height_r, FRAME_MAX_H);
		if (px.frame_start) begin
			column_pos = '0;
			row_pos    = '0;
		end
		z = Z_W'((64'(px.depth_mm) << Z_FRAC) / MM_PER_M);
		// a counter left beyond a shrunken size still ends the row or frame
		row_end      = column_pos >= w - 1;
		pt.frame_end = row_end && (row_pos >= h - 1);
		pt.x         = offset_to_meters(column_pos, center_x_r, focal_x_r, z);
		pt.y         = offset_to_meters(row_pos, center_y_r, focal_y_r, z);
		pt.z         = z;
		pt.color     = px.pixel_color;
		if (row_end) begin
			column_pos = '0;
			row_pos    = pt.frame_end ? '0 : row_pos + 1'b1;
		end else begin
			column_pos = column_pos + 1'b1;
		end
		return pt;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
			error_count++;
		end
	endfunction

	// Wait count before the next beat; flip now and then into or out of a run with no waits.
	function automatic int unsigned draw_gap(inout bit calm);
		if ($urandom_range(0, 39) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 7);
	endfunction

	// Sample both channels at the rising edge: predict on every accepted pixel beat,
	// compare every accepted point beat against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pixel_in.valid && pixel_in.ready) begin
				pending_points.push_back(project_pixel(shown_pixel));
				pixel_taken = 1'b1;
			end
			if (point_out.valid && point_out.ready) begin
				point_taken = 1'b1;
				if (pending_points.size() == 0) begin
					$error("point beat arrived with no pixel outstanding");
					error_count++;
				end else begin
					want = pending_points.pop_front();
					check_field("point_x", want.x, point_out.point_x);
					check_field("point_y", want.y, point_out.point_y);
					check_field("point_z", want.z, point_out.point_z);
					check_field("point_color", want.color, point_out.point_color);
					check_field("frame_end", want.frame_end, point_out.frame_end);
				end
			end
		end
	end

	// Pixel driver: after each accepted beat wait the drawn gap, then present the
	// next queued pixel. Keep valid high across back-to-back beats.
	always @(negedge clk) begin
		if (arst_n) begin
			if (pixel_taken) begin
				pixel_taken = 1'b0;
				pix_busy    = 1'b0;
				pix_gap     = draw_gap(sender_calm);
			end
			if (!pix_busy) begin
				if (pix_gap != 0) begin
					pix_gap--;
				end else if (queued_pixels.size() != 0) begin
					shown_pixel          = queued_pixels.pop_front();
					pix_busy             = 1'b1;
					pixel_in.depth_mm    <= shown_pixel.depth_mm;
					pixel_in.pixel_color <= shown_pixel.pixel_color;
					pixel_in.frame_start <= shown_pixel.frame_start;
				end
			end
			pixel_in.valid <= pix_busy;
		end
	end

	// Point sink: after each accepted beat hold ready low for the drawn stall.
	always @(negedge clk) begin
		if (arst_n) begin
			if (point_taken) begin
				point_taken = 1'b0;
				sink_hold   = draw_gap(sink_calm);
			end
			if (sink_hold != 0) begin
				sink_hold--;
				point_out.ready <= 1'b0;
			end else begin
				point_out.ready <= 1'b1;
			end
		end
	end

	task automatic push_pixel(input logic [DEPTH_W-1:0] depth, input logic [COLOR_W-1:0] color,
			input logic start);
		pixel_t px;
		px.depth_mm    = depth;
		px.pixel_color = color;
		px.frame_start = start;
		queued_pixels.push_back(px);
	endtask

	// Hold until nothing is queued, in flight or outstanding.
	task automatic wait_idle();
		while (queued_pixels.size() != 0 || pix_busy || pending_points.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// One register beat; leaves valid high so writes can run back to back.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do
			@(posedge clk);
		while (!cfg.ready);
		case (idx)
			CFG_FRAME_WIDTH:  frame_width_r  = value[SIZE_W-1:0];
			CFG_FRAME_HEIGHT: frame_height_r = value[SIZE_W-1:0];
			CFG_CENTER_X:     center_x_r     = value;
			CFG_CENTER_Y:     center_y_r     = value;
			CFG_FOCAL_X:      focal_x_r      = value;
			CFG_FOCAL_Y:      focal_y_r      = value;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [15:0] w, input logic [15:0] h, input logic [15:0] cx,
			input logic [15:0] cy, input logic [15:0] fx, input logic [15:0] fy);
		wait_idle();
		write_reg(CFG_FRAME_WIDTH, w);
		write_reg(CFG_FRAME_HEIGHT, h);
		write_reg(CFG_CENTER_X, cx);
		write_reg(CFG_CENTER_Y, cy);
		write_reg(CFG_FOCAL_X, fx);
		write_reg(CFG_FOCAL_Y, fy);
		if ($urandom_range(0, 3) == 0)
			write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom));
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	initial begin
		int unsigned       random_items;
		int unsigned       phase;
		int unsigned       n_items;
		int unsigned       frame_px;
		int unsigned       k;
		logic [15:0]       w, h, cx, cy, fx, fy;
		logic [DEPTH_W-1:0] depth;
		logic              start;
		bit                far;

		arst_n                = 1'b0;
		cfg.valid             = 1'b0;
		cfg.index             = CFG_FRAME_WIDTH;
		cfg.data              = '0;
		pixel_in.valid        = 1'b0;
		pixel_in.depth_mm     = '0;
		pixel_in.pixel_color  = '0;
		pixel_in.frame_start  = 1'b0;
		point_out.ready       = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: zero depth, depth extremes, the metre boundary, bit patterns.
		push_pixel(16'd0, 32'hFFFF_FFFF, 1'b1);
		push_pixel(16'hFFFF, 32'h0000_0000, 1'b0);
		push_pixel(16'd1, 32'hA5A5_A5A5, 1'b0);
		push_pixel(16'd999, 32'h5A5A_5A5A, 1'b0);
		push_pixel(16'd1000, 32'h0123_4567, 1'b0);
		push_pixel(16'd1001, 32'hFEDC_BA98, 1'b0);
		push_pixel(16'hAAAA, 32'h8000_0001, 1'b0);
		push_pixel(16'h5555, 32'h7FFF_FFFE, 1'b1);

		// Zero sizes act as one pixel; zero focal acts as 1/16 pixel; far principal
		// point drives the lateral terms of the deep pixels into negative saturation.
		configure(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
		push_pixel(16'hFFFF, 32'($urandom), 1'b1);
		push_pixel(16'd0, 32'($urandom), 1'b0);
		push_pixel(16'd1, 32'($urandom), 1'b0);
		push_pixel(16'd40000, 32'($urandom), 1'b0);

		// Oversized width clamps to the maximum; one-pixel and maximum focal lengths.
		configure(16'hFFFF, 16'd3, 16'h8000, 16'd0, 16'd16, 16'hFFFF);
		push_pixel(16'hFFFF, 32'($urandom), 1'b1);
		for (k = 0; k < 5; k++)
			push_pixel(16'($urandom), 32'($urandom), 1'b0);

		// Shrink the frame under a running counter: the stale column ends the row.
		configure(16'd2, 16'd2, 16'd8, 16'd24, 16'd200, 16'd300);
		for (k = 0; k < 5; k++)
			push_pixel(16'($urandom_range(1, 9000)), 32'($urandom), 1'b0);

		// Random phases: each one waits for the pipeline to drain, loads new settings,
		// then streams raster frames with occasional stray frame starts.
		random_items = 0;
		phase        = 0;
		while (random_items < RANDOM_ITEMS) begin
			far = (phase % 4) == 3;
			case ($urandom_range(0, 9))
				0:       w = 16'($urandom);
				1:       w = 16'd0;
				2:       w = 16'($urandom_range(13, 4096));
				default: w = 16'($urandom_range(1, 12));
			endcase
			case ($urandom_range(0, 9))
				0:       h = 16'($urandom);
				1:       h = 16'd0;
				2:       h = 16'($urandom_range(7, 4096));
				default: h = 16'($urandom_range(1, 6));
			endcase
			if (far)
				w = 16'($urandom_range(40, 4096));
			cx = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
			cy = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 100));
			case ($urandom_range(0, 7))
				0:       fx = 16'($urandom_range(0, 15));
				1:       fx = 16'hFFFF;
				default: fx = 16'($urandom_range(16, 65535));
			endcase
			case ($urandom_range(0, 7))
				0:       fy = 16'($urandom_range(0, 15));
				1:       fy = 16'hFFFF;
				default: fy = 16'($urandom_range(16, 65535));
			endcase
			if (far)
				fx = 16'($urandom_range(0, 15));
			configure(w, h, cx, cy, fx, fy);
			frame_px = clamp_size(frame_width_r, FRAME_MAX_W) *
				clamp_size(frame_height_r, FRAME_MAX_H);
			n_items = $urandom_range(10, 60);
			for (k = 0; k < n_items; k++) begin
				if (k % frame_px == 0)
					start = ($urandom_range(0, 3) != 0);
				else
					start = ($urandom_range(0, 39) == 0);
				case ($urandom_range(0, 7))
					0:       depth = 16'd0;
					1:       depth = 16'($urandom);
					2:       depth = 16'hFFFF;
					default: depth = 16'($urandom_range(1, 8000));
				endcase
				if (far && depth != 0)
					depth = 16'($urandom_range(30000, 65535));
				push_pixel(depth, 32'($urandom), start);
			end
			random_items += n_items;
			phase++;
		end

		wait_idle();
		repeat (100) @(negedge clk);
		if (error_count == 0)
			$display("[depth_to_point_cloud_unit] OK");
		else
			$display("[depth_to_point_cloud_unit] ERROR");
		$finish;
	end

	// Watchdog: several times the slowest legal run.
	initial begin
		#1000000;
		$display("[depth_to_point_cloud_unit] ERROR");
		$finish;
	end

endmodule
